FILE: rtl/lbed_pkg.sv
// Package for the leading-bit-estimate divider.
// Holds shared constants, the sequencer state type and the add-unit control struct.
// No dependencies.
package lbed_pkg;

   // Width of every operand and result field on the channels.
   localparam int FIELD_WIDTH = 31;

   // Default datapath width of the divider.
   localparam int WORD_WIDTH_DEFAULT = 32;

   // Leading-bit positions and shift distances. The datapath is at most
   // FIELD_WIDTH + 3 bits wide, so six bits hold every position.
   localparam int POS_WIDTH = 6;

   typedef logic [POS_WIDTH-1:0] pos_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD_DIV,
      ST_LEAD_REM,
      ST_STEP,
      ST_FIX,
      ST_DONE
   } state_type;

   // Control for the shared shift-and-add unit.
   typedef struct packed {
      logic    sub;    // subtract the shifted divisor and raise the quotient
      pos_type shift;  // left shift applied to divisor and quotient weight
   } alu_ctrl_type;

endpackage

FILE: rtl/lbed_if.sv
// Channel interfaces for the leading-bit-estimate divider.
// Depends on lbed_pkg for the field width.
interface lbed_req_if import lbed_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] dividend;
   logic [FIELD_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface lbed_rsp_if import lbed_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] quotient;
   logic [FIELD_WIDTH-1:0] remainder;
   logic                   divide_by_zero;

   modport source (output valid, output quotient, output remainder,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input remainder,
                   input divide_by_zero, output ready);
endinterface

FILE: rtl/lbed_lead.sv
// Leading-bit position encoder of the divider.
// Depends on lbed_pkg for the position type.
module lbed_lead import lbed_pkg::*; #(
   parameter int DATA_WIDTH = 34
) (
   input  logic signed [DATA_WIDTH-1:0] value,
   output pos_type                      pos
);

   logic [DATA_WIDTH-1:0] mag;

   // A negative value is located by its leading zero, which is the leading
   // one of its complement.
   assign mag = value[DATA_WIDTH-1] ? ~value : value;

   always_comb begin
      pos = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (mag[i]) begin
            pos = POS_WIDTH'(i + 1);
         end
      end
   end

endmodule

FILE: rtl/lbed_alu.sv
// Shared shift-and-add unit of the divider: moves the partial remainder by a
// shifted divisor and the quotient by the matching power of two.
// Depends on lbed_pkg for the control struct.
module lbed_alu import lbed_pkg::*; #(
   parameter int DATA_WIDTH = 34
) (
   input  alu_ctrl_type                 ctrl,
   input  logic signed [DATA_WIDTH-1:0] rem_cur,
   input  logic signed [DATA_WIDTH-1:0] quo_cur,
   input  logic        [DATA_WIDTH-1:0] divisor,
   output logic signed [DATA_WIDTH-1:0] rem_next,
   output logic signed [DATA_WIDTH-1:0] quo_next
);

   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH-1:0] weight;

   assign shifted = divisor << ctrl.shift;
   assign weight  = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << ctrl.shift;

   always_comb begin
      if (ctrl.sub) begin
         rem_next = rem_cur - signed'(shifted);
         quo_next = quo_cur + signed'(weight);
      end else begin
         rem_next = rem_cur + signed'(shifted);
         quo_next = quo_cur - signed'(weight);
      end
   end

endmodule

FILE: rtl/leading_bit_estimate_divider_unit.sv
// Leading-bit-estimate integer divider, top level with its sequencer.
// Depends on lbed_pkg, lbed_if, lbed_lead and lbed_alu.
//
// The req channel carries one item: an unsigned dividend and divisor. The rsp
// channel returns one item per request: the floor quotient, the remainder and
// a divide-by-zero flag. Both channels use valid/ready; an item moves at a
// rising clock edge where both are high.
//
// The block handles one item at a time. req ready is high only while the
// sequencer is idle. An item first has its divisor's leading-bit position
// encoded. Each reduction step then encodes the partial remainder's position
// and adds or subtracts the shifted divisor in the shared adder. Each step
// lowers the remainder's position by at least one, so there are at most
// OPW - 1 steps, where OPW is the operand width (31 at the default width). A
// correction follows: at most two additions or one subtraction, then a final
// check that finds the remainder in range. The next item is taken only after
// the result has been taken on rsp and the sequencer is back in idle. A zero
// divisor goes straight to the done state, so its result is valid in the
// cycle after the item is taken.
//
// The result stays valid and stable until rsp ready is seen; no new request is
// taken meanwhile. A synchronous reset returns the sequencer to idle and drops
// rsp valid; the datapath registers are not reset.
module leading_bit_estimate_divider_unit import lbed_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   lbed_req_if.sink      req_ch,
   lbed_rsp_if.source    rsp_ch
);

   // Operand width: one bit below the word width, capped by the field width.
   localparam int OPW = (WORD_WIDTH - 1 < FIELD_WIDTH) ? (WORD_WIDTH - 1) : FIELD_WIDTH;
   // Signed datapath width: room for a remainder down to minus twice the
   // divisor and for a divisor shifted up to the remainder's position.
   localparam int RW  = OPW + 3;
   // Step counter width, able to hold WORD_WIDTH + 1.
   localparam int GW  = $clog2(WORD_WIDTH + 2);

   state_type             state_ff, state_in;
   logic signed [RW-1:0]  rem_ff, rem_in;
   logic signed [RW-1:0]  quo_ff, quo_in;
   logic [RW-1:0]         div_ff, div_in;
   pos_type               px_ff, px_in;
   pos_type               shift_ff, shift_in;
   logic [GW-1:0]         guard_ff, guard_in;
   logic                  dbz_ff, dbz_in;

   logic [RW-1:0]         div_req;
   logic signed [RW-1:0]  lead_value;
   pos_type               lead_pos;
   alu_ctrl_type          alu_ctrl;
   logic signed [RW-1:0]  alu_rem;
   logic signed [RW-1:0]  alu_quo;
   logic                  req_fire;
   logic                  rsp_fire;

   assign div_req  = RW'(req_ch.divisor[OPW-1:0]);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // One encoder serves both the divisor and the partial remainder.
   assign lead_value = (state_ff == ST_LEAD_DIV) ? signed'(div_ff) : rem_ff;

   lbed_lead #(
      .DATA_WIDTH (RW)
   ) u_lead (
      .value (lead_value),
      .pos   (lead_pos)
   );

   lbed_alu #(
      .DATA_WIDTH (RW)
   ) u_alu (
      .ctrl     (alu_ctrl),
      .rem_cur  (rem_ff),
      .quo_cur  (quo_ff),
      .divisor  (div_ff),
      .rem_next (alu_rem),
      .quo_next (alu_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      px_ff    <= px_in;
      shift_ff <= shift_in;
      guard_ff <= guard_in;
      dbz_ff   <= dbz_in;
   end

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_in         = div_ff;
      px_in          = px_ff;
      shift_in       = shift_ff;
      guard_in       = guard_ff;
      dbz_in         = dbz_ff;
      req_ch.ready   = 1'b0;
      alu_ctrl.sub   = ~rem_ff[RW-1];
      alu_ctrl.shift = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               div_in   = div_req;
               quo_in   = '0;
               guard_in = '0;
               if (div_req == '0) begin
                  rem_in   = '0;
                  dbz_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  rem_in   = RW'(req_ch.dividend[OPW-1:0]);
                  dbz_in   = 1'b0;
                  state_in = ST_LEAD_DIV;
               end
            end
         end
         ST_LEAD_DIV: begin
            px_in    = lead_pos;
            state_in = ST_LEAD_REM;
         end
         ST_LEAD_REM: begin
            // Keep reducing while the remainder sits above the divisor.
            if ((lead_pos > px_ff) && (guard_ff <= GW'(WORD_WIDTH))) begin
               shift_in = lead_pos - px_ff;
               state_in = ST_STEP;
            end else begin
               state_in = ST_FIX;
            end
         end
         ST_STEP: begin
            alu_ctrl.shift = shift_ff;
            rem_in         = alu_rem;
            quo_in         = alu_quo;
            guard_in       = guard_ff + 1'b1;
            state_in       = ST_LEAD_REM;
         end
         ST_FIX: begin
            // A negative remainder takes the divisor back; a nonnegative one
            // gives it up once more only if the difference stays nonnegative.
            if (rem_ff[RW-1] || !alu_rem[RW-1]) begin
               rem_in = alu_rem;
               quo_in = alu_quo;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The final quotient and remainder are nonnegative and below 2**OPW.
   assign rsp_ch.valid          = (state_ff == ST_DONE);
   assign rsp_ch.quotient       = FIELD_WIDTH'(quo_ff[OPW-1:0]);
   assign rsp_ch.remainder      = FIELD_WIDTH'(rem_ff[OPW-1:0]);
   assign rsp_ch.divide_by_zero = dbz_ff;

endmodule

FILE: rtl/lbed_checker.sv
// Port-level checker for the leading-bit-estimate divider, bound to the top.
// Depends on lbed_pkg and leading_bit_estimate_divider_unit.
module lbed_checker import lbed_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FIELD_WIDTH-1:0] rsp_quotient,
   input logic [FIELD_WIDTH-1:0] rsp_remainder,
   input logic                   rsp_divide_by_zero
);

   // A pending result holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder) && $stable(rsp_divide_by_zero))
      else $error("result changed while stalled");

   // A zero divisor reports zero quotient and remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0 && rsp_remainder == '0)
      else $error("divide-by-zero result not cleared");

   // The unit is busy in the cycle after it takes an item.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // No new item is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while result pending");

endmodule

bind leading_bit_estimate_divider_unit lbed_checker u_lbed_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_quotient       (rsp_ch.quotient),
   .rsp_remainder      (rsp_ch.remainder),
   .rsp_divide_by_zero (rsp_ch.divide_by_zero)
);
